// File: hdl/mhpq_pkg.sv
// Types and constants shared by the max-heap priority queue modules.
package mhpq_pkg;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_POP    = 1'b1;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;
	localparam logic [1:0] ST_UNUSED = 2'd3;

	typedef struct packed {
		logic        opcode;
		logic [15:0] entry_id;
		logic [15:0] entry_cost;
		logic [15:0] entry_priority;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] popped_id;
		logic [15:0] popped_cost;
		logic [15:0] popped_priority;
		logic [10:0] entry_count;
	} rsp_t;

	typedef struct packed {
		logic [15:0] id;
		logic [15:0] cost;
		logic [15:0] prio;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef enum logic [2:0] {
		S_IDLE,
		S_UP,
		S_POP_RD,
		S_DOWN,
		S_PLACE,
		S_FINISH
	} state_t;

endpackage

// File: hdl/mhpq_ram.sv
// Generic RAM with one write port and two registered read ports.
module mhpq_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic [WIDTH-1:0]         rdata_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

// File: hdl/max_heap_priority_queue.sv
// Top level of the max-heap priority queue: sequencer over a heap RAM and a result register.
//
//   channel | direction | handshake            | payload
//   request | in        | req_valid, req_stall | req (opcode, entry fields)
//   result  | out       | rsp_valid, rsp_stall | rsp (status, popped entry, count)
//
// One request is worked at a time; the sequencer visits one heap level per cycle.
// An insert climbs from the new slot toward the root; a pop reads the root and the last
// entry, then sifts down one level at a time; rejected requests go straight to the result.
// Reset clears the count and control state; the heap RAM needs no clearing pass.
// A new request is taken while an earlier result still waits in the result register.
module max_heap_priority_queue #(
	parameter int CAPACITY = 1024
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  mhpq_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output mhpq_pkg::rsp_t rsp
);

	import mhpq_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int AW = $clog2(CAPACITY);
	localparam int PW = CW + 1;

	state_t state_q, state_d;

	logic [CW-1:0] cnt_q;
	logic [CW-1:0] pos_q;
	entry_t        x_q;
	entry_t        pop_q;
	logic [1:0]    status_q;
	logic          out_valid_q;
	rsp_t          rsp_q;

	logic [ENTRY_W-1:0] rd_a, rd_b;
	entry_t             ent_a, ent_b;
	logic [AW-1:0]      raddr_a, raddr_b, waddr;
	logic [PW-1:0]      ra_pos, rb_pos, ra_idx, rb_idx, w_idx;
	logic               we;
	entry_t             wdata;

	logic          accept;
	logic          full, empty;
	logic [PW-1:0] cnt_w, ins_pos;
	logic [CW-1:0] parent_pos;
	logic          parent_is_root;
	logic          up_move;
	logic [PW-1:0] left_w, right_w;
	logic          right_ok, pick_right;
	entry_t        pick;
	logic [CW-1:0] pick_pos;
	logic [PW-1:0] next_left;
	logic          has_kids;
	logic          down_move;
	logic          slot_free;
	logic [CW+10:0] cnt_ext;

	assign ent_a = entry_t'(rd_a);
	assign ent_b = entry_t'(rd_b);

	assign accept = req_valid && !req_stall;
	assign full   = cnt_q == CW'(CAPACITY);
	assign empty  = cnt_q == '0;
	assign cnt_w  = {1'b0, cnt_q};
	assign ins_pos = cnt_w + PW'(1);

	assign parent_pos     = pos_q >> 1;
	assign parent_is_root = parent_pos == CW'(1);
	assign up_move        = ent_a.prio < x_q.prio;

	assign left_w     = {pos_q, 1'b0};
	assign right_w    = left_w + PW'(1);
	assign right_ok   = right_w <= cnt_w;
	assign pick_right = right_ok && !(ent_a.prio > ent_b.prio);
	assign pick       = pick_right ? ent_b : ent_a;
	assign pick_pos   = pick_right ? right_w[CW-1:0] : left_w[CW-1:0];
	assign down_move  = x_q.prio < pick.prio;
	assign next_left  = {pick_pos, 1'b0};
	assign has_kids   = next_left <= cnt_w;

	assign slot_free = !out_valid_q || !rsp_stall;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					if (req.opcode == OP_INSERT) begin
						if (full) begin
							state_d = S_FINISH;
						end else if (empty) begin
							state_d = S_PLACE;
						end else begin
							state_d = S_UP;
						end
					end else begin
						state_d = empty ? S_FINISH : S_POP_RD;
					end
				end
			end
			S_UP: begin
				if (!up_move) begin
					state_d = S_FINISH;
				end else if (parent_is_root) begin
					state_d = S_PLACE;
				end else begin
					state_d = S_UP;
				end
			end
			S_POP_RD: begin
				state_d = (cnt_q >= CW'(2)) ? S_DOWN : S_PLACE;
			end
			S_DOWN: begin
				if (!down_move) begin
					state_d = S_FINISH;
				end else if (has_kids) begin
					state_d = S_DOWN;
				end else begin
					state_d = S_PLACE;
				end
			end
			S_PLACE: begin
				state_d = S_FINISH;
			end
			S_FINISH: begin
				if (slot_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		ra_pos = PW'(1);
		rb_pos = PW'(1);
		we     = 1'b0;
		wdata  = x_q;
		case (state_q)
			S_IDLE: begin
				if (req.opcode == OP_INSERT) begin
					ra_pos = ins_pos >> 1;
				end else begin
					rb_pos = cnt_w;
				end
			end
			S_UP: begin
				ra_pos = {1'b0, parent_pos >> 1};
				we     = 1'b1;
				wdata  = up_move ? ent_a : x_q;
			end
			S_POP_RD: begin
				ra_pos = PW'(2);
				rb_pos = PW'(3);
			end
			S_DOWN: begin
				ra_pos = next_left;
				rb_pos = next_left + PW'(1);
				we     = 1'b1;
				wdata  = down_move ? pick : x_q;
			end
			S_PLACE: begin
				we = 1'b1;
			end
			S_FINISH: begin
				we = 1'b0;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	assign ra_idx  = ra_pos - PW'(1);
	assign rb_idx  = rb_pos - PW'(1);
	assign w_idx   = {1'b0, pos_q} - PW'(1);
	assign raddr_a = ra_idx[AW-1:0];
	assign raddr_b = rb_idx[AW-1:0];
	assign waddr   = w_idx[AW-1:0];

	mhpq_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk(clk),
		.we(we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr_a(raddr_a),
		.rdata_a(rd_a),
		.raddr_b(raddr_b),
		.rdata_b(rd_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				if (req.opcode == OP_INSERT && !full) begin
					cnt_q <= cnt_q + CW'(1);
				end else if (req.opcode == OP_POP && !empty) begin
					cnt_q <= cnt_q - CW'(1);
				end
			end
			if (state_q == S_FINISH && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign cnt_ext = {11'b0, cnt_q};

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					pop_q  <= '0;
					pos_q  <= ins_pos[CW-1:0];
					x_q    <= '{id: req.entry_id, cost: req.entry_cost,
						prio: req.entry_priority};
					if (req.opcode == OP_INSERT) begin
						status_q <= full ? ST_FULL : ST_OK;
					end else begin
						status_q <= empty ? ST_EMPTY : ST_OK;
					end
				end
			end
			S_UP: begin
				if (up_move) begin
					pos_q <= parent_pos;
				end
			end
			S_POP_RD: begin
				pop_q <= ent_a;
				x_q   <= ent_b;
				pos_q <= CW'(1);
			end
			S_DOWN: begin
				if (down_move) begin
					pos_q <= pick_pos;
				end
			end
			S_FINISH: begin
				if (slot_free) begin
					rsp_q.status          <= status_q;
					rsp_q.popped_id       <= pop_q.id;
					rsp_q.popped_cost     <= pop_q.cost;
					rsp_q.popped_priority <= pop_q.prio;
					rsp_q.entry_count     <= cnt_ext[10:0];
				end
			end
			default: begin
				pos_q <= pos_q;
			end
		endcase
	end

	assign req_stall = state_q != S_IDLE;
	assign rsp_valid = out_valid_q;
	assign rsp       = rsp_q;

endmodule

// File: hdl/mhpq_chk.sv
// Port-level assertions for the max-heap priority queue and their binding.
module mhpq_chk (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_stall,
	input logic           rsp_valid,
	input logic           rsp_stall,
	input mhpq_pkg::rsp_t rsp
);

	import mhpq_pkg::*;

	// A stalled result must hold its value.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled result changed");

	// The block is busy in the cycle after it takes a request.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request taken without going busy");

	// A pop on an empty heap reports no entry and an empty count.
	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ST_EMPTY |->
			rsp.entry_count == '0 && rsp.popped_priority == '0 && rsp.popped_id == '0)
		else $error("empty pop result not clean");

	// Only defined status codes appear, and rejected (non-OK) results carry a zero popped cost.
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != ST_OK |->
			rsp.status != ST_UNUSED && rsp.popped_cost == '0)
		else $error("bad status or stray entry in result");

endmodule

bind max_heap_priority_queue mhpq_chk u_mhpq_chk (.*);
